FILE: sv/ort_pkg.sv
// ----------------------------------------------------------------------------
// ort_pkg
// shared constants and types of the oriented rectangle overlap test
// ----------------------------------------------------------------------------
`default_nettype none

package ort_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int CORNERS        = 4;
    localparam int NUM_COORDS     = 2 * CORNERS;
    localparam int AXES           = 2 * CORNERS;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TEST = 1'b1
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_qctl;

endpackage

`default_nettype wire

FILE: sv/ort_if.sv
// ----------------------------------------------------------------------------
// ort_if
// valid/ready channels for rectangle words and overlap result words
// ----------------------------------------------------------------------------
`default_nettype none

interface ort_in_if #(
    parameter int COORD_BITS = ort_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y2;
    logic [COORD_BITS-1:0] x3;
    logic [COORD_BITS-1:0] y3;

    modport source (output valid, cmd, x0, y0, x1, y1, x2, y2, x3, y3, input ready);
    modport sink   (input valid, cmd, x0, y0, x1, y1, x2, y2, x3, y3, output ready);
endinterface

interface ort_out_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink   (input valid, overlap, output ready);
endinterface

`default_nettype wire

FILE: sv/oriented_rect_overlap_test_top.sv
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test_top
// separating axis overlap test for two four-corner rectangles
// ----------------------------------------------------------------------------
// A word with cmd 0 stores its four corners as the reference rectangle and
// gives no result; a word with cmd 1 is tested against the stored rectangle
// and gives one result word, overlap 1 unless some edge of either rectangle
// separates the two projected intervals (touching counts as overlap).
// Corners are signed Q15.8, given in order around the outline. A load is
// stored when the engine pops it; a test starts when popped, runs the eight
// axes through the projection pipeline (sixteen multipliers, one axis per
// cycle) and then drains it. A two-word queue in front lets input words
// arrive while a test runs or a result waits. Test only after a load.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_rect_overlap_test_top #(
    parameter int COORD_BITS = ort_pkg::COORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ort_in_if.sink    i_in,
    ort_out_if.source o_out
);
    import ort_pkg::*;

    t_qctl                                 w_qctl;
    logic [NUM_COORDS-1:0][COORD_BITS-1:0] w_crn;
    logic                                  w_pop;

    ort_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_qctl  (w_qctl),
        .o_crn   (w_crn)
    );

    ort_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qctl  (w_qctl),
        .i_crn   (w_crn),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: sv/ort_front.sv
// ----------------------------------------------------------------------------
// ort_front
// accepts rectangle words, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
`default_nettype none

module ort_front #(
    parameter int COORD_BITS = ort_pkg::COORD_BITS_DEF
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    ort_in_if.sink                                               i_in,
    input  wire logic                                            i_pop,
    output ort_pkg::t_qctl                                       o_qctl,
    output logic [ort_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]       o_crn
);
    import ort_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_kind                                r_kind [QUEUE_DEPTH];
    logic [NUM_COORDS-1:0][COORD_BITS-1:0] r_crn [QUEUE_DEPTH];
    logic [PTR_W-1:0]                     r_wp;
    logic [PTR_W-1:0]                     r_rp;
    logic [CNT_W-1:0]                     r_cnt;
    logic [PTR_W-1:0]                     n_wp;
    logic [PTR_W-1:0]                     n_rp;
    logic                                 w_push;
    t_kind                                w_kind;
    logic [NUM_COORDS-1:0][COORD_BITS-1:0] w_crn;

    assign i_in.ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;

    always_comb begin
        unique case (i_in.cmd)
            CMD_LOAD: w_kind = KIND_LOAD;
            CMD_TEST: w_kind = KIND_TEST;
            default:  w_kind = KIND_LOAD;
        endcase
    end

    assign w_crn = {i_in.y3, i_in.x3, i_in.y2, i_in.x2,
                    i_in.y1, i_in.x1, i_in.y0, i_in.x0};

    assign n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind[r_wp] <= w_kind;
            r_crn[r_wp]  <= w_crn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_qctl.valid = (r_cnt != '0);
    assign o_qctl.kind  = r_kind[r_rp];
    assign o_crn        = r_crn[r_rp];

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pop from empty queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_pop) |=> (r_cnt == CNT_W'($past(r_cnt) + 1'b1)))
        else $error("queue count not advanced on push");

endmodule

`default_nettype wire

FILE: sv/ort_back.sv
// ----------------------------------------------------------------------------
// ort_back
// separating axis engine: one axis per cycle through a projection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module ort_back #(
    parameter int COORD_BITS = ort_pkg::COORD_BITS_DEF
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire ort_pkg::t_qctl                                  i_qctl,
    input  wire logic [ort_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]  i_crn,
    output logic                                                 o_pop,
    ort_out_if.source                                            o_out
);
    import ort_pkg::*;

    localparam int EW     = COORD_BITS + 1;
    localparam int PW     = 2 * COORD_BITS + 1;
    localparam int SW     = 2 * COORD_BITS + 2;
    localparam int CNT_W  = $clog2(AXES + 1);
    localparam int STAGES = 4;
    localparam int NPROJ  = 2 * CORNERS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state                         r_state;
    logic [CNT_W-1:0]               r_cnt;
    logic [STAGES-1:0]              r_vld;
    logic                           r_sep;
    logic                           r_out_valid;
    logic                           r_overlap;

    logic signed [COORD_BITS-1:0]   r_a  [NUM_COORDS];
    logic signed [COORD_BITS-1:0]   r_b  [NUM_COORDS];
    logic signed [EW-1:0]           r_ex [AXES];
    logic signed [EW-1:0]           r_ey [AXES];
    logic signed [PW-1:0]           r_mx [NPROJ];
    logic signed [PW-1:0]           r_my [NPROJ];
    logic signed [SW-1:0]           r_d  [NPROJ];
    logic signed [SW-1:0]           r_lo1 [4];
    logic signed [SW-1:0]           r_hi1 [4];
    logic signed [SW-1:0]           r_lo2 [2];
    logic signed [SW-1:0]           r_hi2 [2];

    logic signed [COORD_BITS-1:0]   w_cx [NPROJ];
    logic signed [COORD_BITS-1:0]   w_cy [NPROJ];
    logic signed [EW-1:0]           w_ex [AXES];
    logic signed [EW-1:0]           w_ey [AXES];
    logic                           w_start;
    logic                           w_out_free;
    logic                           w_gap;
    logic                           w_done;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == ST_IDLE) && i_qctl.valid;
    assign w_start    = o_pop && (i_qctl.kind == KIND_TEST);
    assign w_gap      = (r_hi2[0] < r_lo2[1]) || (r_hi2[1] < r_lo2[0]);
    assign w_done     = (r_state == ST_DRAIN) && (r_vld == '0) && w_out_free;

    // corners 0..3 from the stored rectangle, 4..7 from the test rectangle
    always_comb begin
        for (int j = 0; j < CORNERS; j++) begin
            w_cx[j]           = r_a[2 * j];
            w_cy[j]           = r_a[2 * j + 1];
            w_cx[CORNERS + j] = r_b[2 * j];
            w_cy[CORNERS + j] = r_b[2 * j + 1];
        end
    end

    // edge vectors: stored rectangle first, then the incoming one
    always_comb begin
        for (int e = 0; e < CORNERS; e++) begin
            w_ex[e] = EW'($signed(r_a[2 * ((e + 1) % CORNERS)]))
                    - EW'($signed(r_a[2 * e]));
            w_ey[e] = EW'($signed(r_a[2 * ((e + 1) % CORNERS) + 1]))
                    - EW'($signed(r_a[2 * e + 1]));
            w_ex[CORNERS + e] = EW'($signed(i_crn[2 * ((e + 1) % CORNERS)]))
                              - EW'($signed(i_crn[2 * e]));
            w_ey[CORNERS + e] = EW'($signed(i_crn[2 * ((e + 1) % CORNERS) + 1]))
                              - EW'($signed(i_crn[2 * e + 1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_qctl.kind == KIND_LOAD)) begin
            for (int k = 0; k < NUM_COORDS; k++) begin
                r_a[k] <= i_crn[k];
            end
        end
        if (w_start) begin
            for (int k = 0; k < NUM_COORDS; k++) begin
                r_b[k] <= i_crn[k];
            end
            for (int e = 0; e < AXES; e++) begin
                r_ex[e] <= w_ex[e];
                r_ey[e] <= w_ey[e];
            end
        end else if (r_state == ST_RUN) begin
            for (int e = 0; e < AXES - 1; e++) begin
                r_ex[e] <= r_ex[e + 1];
                r_ey[e] <= r_ey[e + 1];
            end
        end
    end

    // projection pipeline: products, sums, pair min/max, interval ends
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NPROJ; j++) begin
            r_mx[j] <= PW'(r_ex[0]) * PW'(w_cx[j]);
            r_my[j] <= PW'(r_ey[0]) * PW'(w_cy[j]);
            r_d[j]  <= SW'(r_mx[j]) + SW'(r_my[j]);
        end
        for (int p = 0; p < 4; p++) begin
            r_lo1[p] <= (r_d[2 * p + 1] < r_d[2 * p]) ? r_d[2 * p + 1] : r_d[2 * p];
            r_hi1[p] <= (r_d[2 * p] < r_d[2 * p + 1]) ? r_d[2 * p + 1] : r_d[2 * p];
        end
        for (int g = 0; g < 2; g++) begin
            r_lo2[g] <= (r_lo1[2 * g + 1] < r_lo1[2 * g]) ? r_lo1[2 * g + 1] : r_lo1[2 * g];
            r_hi2[g] <= (r_hi1[2 * g] < r_hi1[2 * g + 1]) ? r_hi1[2 * g + 1] : r_hi1[2 * g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_vld       <= '0;
            r_sep       <= 1'b0;
            r_out_valid <= 1'b0;
            r_overlap   <= 1'b0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], (r_state == ST_RUN)};
            if (r_vld[STAGES-1] && w_gap) begin
                r_sep <= 1'b1;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                        r_sep   <= 1'b0;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(AXES - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_done) begin
                        r_overlap   <= !r_sep;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.overlap = r_overlap;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_vld == '0))
        else $error("projection pipeline busy while idle");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(AXES))
        else $error("axis count out of range");

    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DRAIN))
        else $error("result word not produced at end of drain");

endmodule

`default_nettype wire
